// ===== src/oes_pkg.sv =====
// Shared types and codes for the odd-only sieve.
// Used by oes_ctrl, oes_dp and the top level.
package oes_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MARK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start_load;
    logic clr_step;
    logic scan_rd;
    logic scan_adv;
    logic take;
    logic mark_step;
    logic res_start;
    logic res_hit;
    logic res_miss;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic scan_end;
    logic marked;
    logic mark_needed;
    logic mark_done;
    logic out_free;
  } status_t;

endpackage

// ===== src/oes_ctrl.sv =====
// Sequencer for the sieve: start/clear, scan, mark and result beat.
// Depends on oes_pkg; drives oes_dp through ctrl_t, reads status_t.
module oes_ctrl
  import oes_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  logic    cmd,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (cmd == CMD_START) begin
            ctrl.start_load = 1'b1;
            state_next      = S_CLEAR;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_CLEAR: begin
        if (status.clr_done) begin
          ctrl.res_start = 1'b1;
          state_next     = S_DONE;
        end else begin
          ctrl.clr_step = 1'b1;
        end
      end
      S_SCAN_RD: begin
        if (status.scan_end) begin
          ctrl.res_miss = 1'b1;
          state_next    = S_DONE;
        end else begin
          ctrl.scan_rd = 1'b1;
          state_next   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (status.marked) begin
          ctrl.scan_adv = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (status.mark_needed) begin
          ctrl.take  = 1'b1;
          state_next = S_MARK;
        end else begin
          ctrl.res_hit = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_MARK: begin
        if (status.mark_done) begin
          ctrl.res_hit = 1'b1;
          state_next   = S_DONE;
        end else begin
          ctrl.mark_step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/oes_dp.sv =====
// Sieve datapath: composite bit store, cursor, stride/mark index, result register.
// Depends on oes_pkg; commanded by oes_ctrl.
module oes_dp
  import oes_pkg::*;
#(
  parameter int ODD_SLOTS = 32768
)
(
  input  logic          clk,
  input  logic          rst,
  input  ctrl_t         ctrl,
  output status_t       status,
  input  logic [15:0]   limit,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [15:0]   prime,
  output logic          found
);

  localparam int AW = $clog2(ODD_SLOTS);
  localparam int CW = $clog2(ODD_SLOTS + 1);
  localparam int XW = (CW + 1 > 17) ? CW + 1 : 17;
  localparam int PW = (CW + 1 > 16) ? CW + 1 : 16;

  logic           map [ODD_SLOTS];
  logic           rd_bit;
  logic [CW-1:0]  count;
  logic [CW-1:0]  cur;
  logic [CW:0]    idx;
  logic [CW:0]    step;
  logic           start_found;
  logic [15:0]    pend_prime;
  logic           pend_found;

  logic [16:0]    lim_cnt;
  logic [CW-1:0]  new_count;
  logic [CW:0]    cur_odd;
  logic [PW-1:0]  cur_odd_w;
  logic           we;
  logic           wdata;

  assign lim_cnt   = (17'(limit) + 17'd1) >> 1;
  assign new_count = (XW'(lim_cnt) > XW'(ODD_SLOTS)) ? CW'(ODD_SLOTS) : CW'(lim_cnt);
  assign cur_odd   = {cur, 1'b1};
  assign cur_odd_w = PW'(cur_odd);

  assign we    = ctrl.clr_step | ctrl.mark_step;
  assign wdata = ctrl.clr_step ? (idx == '0) : 1'b1;

  always_ff @(posedge clk) begin
    if (we) begin
      map[idx[AW-1:0]] <= wdata;
    end
    if (ctrl.scan_rd) begin
      rd_bit <= map[cur[AW-1:0]];
    end
  end

  assign status.clr_done    = (idx >= {1'b0, count});
  assign status.scan_end    = (cur >= count);
  assign status.marked      = rd_bit;
  assign status.mark_needed = (cur < (count >> 1));
  assign status.mark_done   = (idx >= {1'b0, count});
  assign status.out_free    = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.start_load) begin
        count <= new_count;
        cur   <= '0;
      end
      if (ctrl.scan_adv || ctrl.res_hit) begin
        cur <= cur + 1'b1;
      end
      if (ctrl.res_miss) begin
        cur <= count;
      end
      if (ctrl.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start_load) begin
      idx         <= '0;
      start_found <= (limit > 16'd1);
    end
    if (ctrl.clr_step) begin
      idx <= idx + 1'b1;
    end
    if (ctrl.take) begin
      step <= cur_odd;
      idx  <= {1'b0, cur} + cur_odd;
    end
    if (ctrl.mark_step) begin
      idx <= idx + step;
    end
    if (ctrl.res_start) begin
      pend_prime <= start_found ? 16'd2 : 16'd0;
      pend_found <= start_found;
    end
    if (ctrl.res_hit) begin
      pend_prime <= cur_odd_w[15:0];
      pend_found <= 1'b1;
    end
    if (ctrl.res_miss) begin
      pend_prime <= 16'd0;
      pend_found <= 1'b0;
    end
    if (ctrl.emit) begin
      prime <= pend_prime;
      found <= pend_found;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cur <= count)
    else $error("cursor beyond active slot count");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (idx < {1'b0, count}))
    else $error("store write outside active slots");

  a_prime_shape: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && pend_found) |-> (pend_prime == 16'd2 || pend_prime[0]))
    else $error("found result is neither 2 nor odd");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten while beat pending");

endmodule

// ===== src/odd_only_eratosthenes_sieve_top.sv =====
// Top level of the odd-only sieve of Eratosthenes.
// Depends on oes_pkg, oes_ctrl and oes_dp.
//
// One request beat gives one response beat. cmd = start (0) sizes the sieve to
// (limit+1)/2 odd slots (capped at ODD_SLOTS) and answers 2, or found = 0 when
// limit < 2; it sweeps the active slots of the bit store one per cycle. cmd = next
// (1) scans from the cursor, each slot through a registered store read, then for a
// slot below half the active count marks its odd multiples one store write per
// cycle. No clearing pass runs after reset; a fetch before any start answers
// found = 0. Requests are taken only while the sequencer is idle; a finished
// response waits in an output register.
module odd_only_eratosthenes_sieve_top
  import oes_pkg::*;
#(
  parameter int ODD_SLOTS = 32768
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        cmd,
  input  logic [15:0] limit,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] prime,
  output logic        found
);

  ctrl_t   ctrl;
  status_t status;

  oes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status),
    .ctrl      (ctrl)
  );

  oes_dp #(
    .ODD_SLOTS (ODD_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .limit     (limit),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .prime     (prime),
    .found     (found)
  );

endmodule
